### rtl/assert_macros.svh
// Assertion macros shared by the RTL of the pixel decoder.
// No dependencies; included by the files that assert.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled in reset.
`define ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

### rtl/bmprgba_pkg.sv
// Package of the BMP pixel decoder: widths, codes and shared types.
// No dependencies.
package bmprgba_pkg;

  localparam int unsigned MAX_DIM_DEF     = 4096;
  localparam int unsigned PAL_ENTRIES_DEF = 256;
  localparam int unsigned DIM_W           = 13;
  localparam int unsigned COLOR_W         = 24;
  localparam int unsigned DEST_W          = 24;
  localparam int unsigned IDX_W           = 8;
  localparam int unsigned QUEUE_DEPTH     = 4;
  localparam int unsigned S_DATA_W        = 40;
  localparam int unsigned M_DATA_W        = 56;
  localparam int unsigned OP_W            = 2;
  localparam int unsigned CFG_IDX_W       = 3;
  localparam int unsigned CFG_DATA_W      = 13;
  localparam logic [7:0]  KEY_LIMIT       = 8'd253;
  localparam logic [7:0]  ALPHA_OPAQUE    = 8'd255;

  typedef enum logic [OP_W-1:0] {
    OP_PAL_WR = 2'd0,
    OP_PIXEL  = 2'd1,
    OP_START  = 2'd2
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WIDTH       = 3'd0,
    CFG_HEIGHT      = 3'd1,
    CFG_PIXEL_MODE  = 3'd2,
    CFG_ALPHA_MODE  = 3'd3,
    CFG_ALPHA_VALUE = 3'd4
  } cfg_idx_t;

  typedef enum logic [1:0] {
    Q_PAL_WR  = 2'd0,
    Q_PAL_PIX = 2'd1,
    Q_RGB_PIX = 2'd2
  } q_kind_t;

  typedef struct packed {
    logic [DIM_W-1:0] width;
    logic [DIM_W-1:0] height;
    logic             pixel_mode;
    logic             alpha_mode;
    logic [7:0]       alpha_value;
  } cfg_t;

  typedef struct packed {
    q_kind_t            kind;
    logic [IDX_W-1:0]   addr;
    logic [COLOR_W-1:0] color;
    logic [DEST_W-1:0]  base;
    logic [DIM_W-1:0]   col;
    logic               last;
  } q_entry_t;

endpackage

### rtl/bmprgba_front.sv
// Front end: classifies input items, tracks row/column/padding, queues work.
// Depends on bmprgba_pkg.
module bmprgba_front import bmprgba_pkg::*; #(
  parameter int unsigned MAX_DIM         = MAX_DIM_DEF,
  parameter int unsigned PALETTE_ENTRIES = PAL_ENTRIES_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  cfg_t               cfg,
  input  logic               accept,
  input  logic [OP_W-1:0]    op,
  input  logic [7:0]         data_byte,
  input  logic [IDX_W-1:0]   palette_index,
  input  logic [COLOR_W-1:0] palette_color,
  output logic               push,
  output q_entry_t           entry,
  output logic               done
);

  localparam int unsigned DIM_CAP = (MAX_DIM < 8191) ? MAX_DIM : 8191;
  localparam int unsigned CNT_W   = $clog2(DIM_CAP);
  localparam int unsigned INC_W   = DIM_W + 1;
  localparam int unsigned PROD_W  = DEST_W + DIM_W;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] r;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (32'(v) > MAX_DIM) begin
      r = DIM_W'(MAX_DIM);
    end else begin
      r = v;
    end
    return r;
  endfunction

  logic [CNT_W-1:0]  col, col_next;
  logic [CNT_W-1:0]  row, row_next;
  logic [1:0]        phase, phase_next;
  logic [15:0]       hold, hold_next;
  logic [1:0]        pad, pad_next;
  logic              done_next;

  logic [DIM_W-1:0]  w, h;
  logic [DEST_W-1:0] row_term;
  logic [PROD_W-1:0] prod_full;
  logic [INC_W-1:0]  col_inc, row_inc;
  logic              emit;
  q_kind_t           emit_kind;
  logic [COLOR_W-1:0] emit_color;

  assign w         = clamp_dim(cfg.width);
  assign h         = clamp_dim(cfg.height);
  assign row_term  = DEST_W'(h) - DEST_W'(1) - DEST_W'(row);
  assign prod_full = PROD_W'(row_term) * PROD_W'(w);
  assign col_inc   = INC_W'(col) + INC_W'(1);
  assign row_inc   = INC_W'(row) + INC_W'(1);

  always_comb begin
    col_next   = col;
    row_next   = row;
    phase_next = phase;
    hold_next  = hold;
    pad_next   = pad;
    done_next  = done;
    emit       = 1'b0;
    emit_kind  = Q_RGB_PIX;
    emit_color = '0;
    push       = 1'b0;
    entry      = '{kind: Q_PAL_WR, addr: palette_index, color: palette_color,
                   base: prod_full[DEST_W-1:0], col: DIM_W'(col), last: 1'b0};
    if (accept) begin
      unique case (op)
        OP_PAL_WR: begin
          if (32'(palette_index) < PALETTE_ENTRIES) push = 1'b1;
        end
        OP_START: begin
          col_next   = '0;
          row_next   = '0;
          phase_next = '0;
          hold_next  = '0;
          pad_next   = '0;
          done_next  = 1'b0;
        end
        OP_PIXEL: begin
          if (!done) begin
            if (pad != 2'd0) begin
              pad_next = pad - 2'd1;
            end else if (!cfg.pixel_mode) begin
              phase_next = '0;
              emit       = 1'b1;
              if (32'(data_byte) < PALETTE_ENTRIES) emit_kind = Q_PAL_PIX;
            end else begin
              unique case (phase)
                2'd0: begin
                  hold_next  = {8'h00, data_byte};
                  phase_next = 2'd1;
                end
                2'd1: begin
                  hold_next  = {data_byte, hold[7:0]};
                  phase_next = 2'd2;
                end
                default: begin
                  phase_next = '0;
                  emit       = 1'b1;
                  emit_color = {data_byte, hold[15:8], hold[7:0]};
                end
              endcase
            end
          end
        end
        default: ;
      endcase
    end

    if (emit) begin
      push        = 1'b1;
      entry.kind  = emit_kind;
      entry.addr  = data_byte;
      entry.color = emit_color;
      if (col_inc >= INC_W'(w)) begin
        pad_next = cfg.pixel_mode ? w[1:0] : 2'(3'd4 - {1'b0, w[1:0]});
        col_next = '0;
        if (row_inc >= INC_W'(h)) begin
          done_next  = 1'b1;
          entry.last = 1'b1;
        end else begin
          row_next = row + CNT_W'(1);
        end
      end else begin
        col_next = col + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col   <= '0;
      row   <= '0;
      phase <= '0;
      hold  <= '0;
      pad   <= '0;
      done  <= 1'b0;
    end else begin
      col   <= col_next;
      row   <= row_next;
      phase <= phase_next;
      hold  <= hold_next;
      pad   <= pad_next;
      done  <= done_next;
    end
  end

endmodule

### rtl/bmprgba_queue.sv
// Small FIFO of work entries between front and back end.
// Depends on bmprgba_pkg.
module bmprgba_queue import bmprgba_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  q_entry_t wr_entry,
  output logic     full,
  input  logic     pop,
  output logic     valid,
  output q_entry_t rd_entry
);

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  q_entry_t          slots [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr, rd_ptr;
  logic [CNT_W-1:0]  count;
  logic              do_push, do_pop;

  assign full     = (count == CNT_W'(QUEUE_DEPTH));
  assign valid    = (count != '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && valid;
  assign rd_entry = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) slots[wr_ptr] <= wr_entry;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (32'(wr_ptr) == QUEUE_DEPTH - 1) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (32'(rd_ptr) == QUEUE_DEPTH - 1) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

### rtl/bmprgba_back.sv
// Back end: palette memory, lookup stage, alpha and index finish, output register.
// Depends on bmprgba_pkg.
module bmprgba_back import bmprgba_pkg::*; #(
  parameter int unsigned PALETTE_ENTRIES = PAL_ENTRIES_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  cfg_t                cfg,
  input  logic                q_valid,
  input  q_entry_t            q_entry,
  output logic                q_pop,
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [M_DATA_W-1:0] m_tdata,
  output logic                m_tlast
);

  localparam int unsigned PAL_AW = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;

  logic [COLOR_W-1:0] palette [PALETTE_ENTRIES];
  logic [COLOR_W-1:0] rd_data;

  logic               s1_valid, s1_move;
  q_entry_t           s1;
  logic               is_write;

  logic [COLOR_W-1:0] color;
  logic [7:0]         red, green, blue, alpha;

  logic               o_valid, o_last;
  logic [DEST_W-1:0]  o_dest;
  logic [7:0]         o_red, o_green, o_blue, o_alpha;

  assign is_write = (q_entry.kind == Q_PAL_WR);
  assign s1_move  = s1_valid && (!o_valid || m_tready);
  assign q_pop    = q_valid && (is_write || !s1_valid || s1_move);

  always_ff @(posedge clk) begin
    if (q_pop && is_write) palette[q_entry.addr[PAL_AW-1:0]] <= q_entry.color;
    if (q_pop && q_entry.kind == Q_PAL_PIX) rd_data <= palette[q_entry.addr[PAL_AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (q_pop && !is_write) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && !is_write) s1 <= q_entry;
  end

  assign color = (s1.kind == Q_PAL_PIX) ? rd_data : s1.color;
  assign red   = color[23:16];
  assign green = color[15:8];
  assign blue  = color[7:0];

  always_comb begin
    if (cfg.alpha_mode) begin
      alpha = cfg.alpha_value;
    end else if (green == 8'd0 && red > KEY_LIMIT && blue > KEY_LIMIT) begin
      alpha = 8'd0;
    end else begin
      alpha = ALPHA_OPAQUE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (s1_move) begin
      o_valid <= 1'b1;
    end else if (m_tready) begin
      o_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      o_dest  <= s1.base + DEST_W'(s1.col);
      o_red   <= red;
      o_green <= green;
      o_blue  <= blue;
      o_alpha <= alpha;
      o_last  <= s1.last;
    end
  end

  assign m_tvalid = o_valid;
  assign m_tdata  = {o_alpha, o_blue, o_green, o_red, o_dest};
  assign m_tlast  = o_last;

endmodule

### rtl/bmp_pixel_to_rgba_color_key_unit.sv
// Top level of the BMP pixel decoder: configuration registers, front end,
// work queue and back end. Depends on bmprgba_pkg and assert_macros.svh.
//
// Takes one input item per clock and gives at most one RGBA pixel per clock.
// A palette-mode data byte makes one pixel; in BGR mode every third byte does.
// A pixel passes from the front end through a four-entry queue, the palette
// read register and the output register to the output. The input stalls
// only when that queue is full, which happens only while the output is held
// off. Palette writes travel through the same queue, so a pixel always sees
// every palette write taken before it. Row padding, bytes after the final
// pixel, start and unused op codes give no pixel.
`include "assert_macros.svh"

module bmp_pixel_to_rgba_color_key_unit import bmprgba_pkg::*; #(
  parameter int unsigned MAX_DIM         = MAX_DIM_DEF,
  parameter int unsigned PALETTE_ENTRIES = PAL_ENTRIES_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [S_DATA_W-1:0]   s_tdata,   // data_byte, palette_index, palette_color
  input  logic [OP_W-1:0]       s_tuser,   // op
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [M_DATA_W-1:0]   m_tdata,   // dest_index, red, green, blue, alpha
  output logic                  m_tlast,   // last_pixel
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t     cfg;
  logic     accept;
  logic     q_push, q_full, q_pop, q_valid;
  q_entry_t q_wr_entry, q_rd_entry;
  logic     front_done;

  assign cfg_ready = 1'b1;
  assign s_tready  = !q_full;
  assign accept    = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '{width: DIM_W'(1), height: DIM_W'(1), pixel_mode: 1'b0,
               alpha_mode: 1'b0, alpha_value: ALPHA_OPAQUE};
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_WIDTH:       cfg.width       <= cfg_data[DIM_W-1:0];
        CFG_HEIGHT:      cfg.height      <= cfg_data[DIM_W-1:0];
        CFG_PIXEL_MODE:  cfg.pixel_mode  <= cfg_data[0];
        CFG_ALPHA_MODE:  cfg.alpha_mode  <= cfg_data[0];
        CFG_ALPHA_VALUE: cfg.alpha_value <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  bmprgba_front #(
    .MAX_DIM         (MAX_DIM),
    .PALETTE_ENTRIES (PALETTE_ENTRIES)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .accept        (accept),
    .op            (s_tuser),
    .data_byte     (s_tdata[7:0]),
    .palette_index (s_tdata[15:8]),
    .palette_color (s_tdata[39:16]),
    .push          (q_push),
    .entry         (q_wr_entry),
    .done          (front_done)
  );

  bmprgba_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .wr_entry (q_wr_entry),
    .full     (q_full),
    .pop      (q_pop),
    .valid    (q_valid),
    .rd_entry (q_rd_entry)
  );

  bmprgba_back #(
    .PALETTE_ENTRIES (PALETTE_ENTRIES)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .q_valid  (q_valid),
    .q_entry  (q_rd_entry),
    .q_pop    (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  `ASSERT_NXT(a_start_clears_done, clk, rst, accept && s_tuser == OP_START, !front_done)
  `ASSERT_IMP(a_no_push_when_full, clk, rst, q_full, !q_push)
  `ASSERT_IMP(a_pop_needs_entry, clk, rst, q_pop, q_valid)

endmodule
